FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

FILE: src/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = $clog2(SLOTS);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ENTER  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  // Input item, first field in the highest bits.
  typedef struct packed {
    logic [1:0]         entry_kind;
    logic signed [15:0] entry_score;
    logic signed [15:0] upper_window;
    logic signed [15:0] lower_window;
    logic [5:0]         search_depth;
    logic               side;
    logic [31:0]        key;
    logic [1:0]         op;
  } item_t;

  localparam int unsigned ITEM_W   = $bits(item_t);
  localparam int unsigned S_DATA_W = ((ITEM_W + 7) / 8) * 8;
  localparam int unsigned RES_W    = 18;
  localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;

  // One slot as held in the table RAM.
  typedef struct packed {
    logic               valid;
    logic [31:0]        key;
    logic [5:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         kind;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_clear;
    logic sweep_last;
  } status_t;

endpackage

FILE: src/stt_ram.sv
`timescale 1ns / 1ps
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/stt_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  stt_pkg::status_t status_i,
  output stt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = status_i.is_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      default: state_d = ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cmd_o.accept  = (state_q == ST_IDLE) && s_axis_tvalid;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.sweep   = (state_q == ST_SWEEP);

  `ASSERT_IMPL(a_accept_then_exec, clk_i, rst_ni, cmd_o.accept |=> state_q == ST_EXEC)
  `ASSERT_IMPL(a_clear_starts_sweep, clk_i, rst_ni,
               (cmd_o.exec && status_i.out_free && status_i.is_clear) |=> state_q == ST_SWEEP)
  `ASSERT_NEVER(a_stall_leaves_exec, clk_i, rst_ni,
                $past(cmd_o.exec && !status_i.out_free) && state_q != ST_EXEC)

endmodule

FILE: src/stt_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stt_pkg::item_t                 item_i,
  input  stt_pkg::cmd_t                  cmd_i,
  output stt_pkg::status_t               status_o,
  input  logic                           m_axis_tready,
  output logic                           m_axis_tvalid,
  output logic [stt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  stt_pkg::item_t             item_q;
  stt_pkg::entry_t            rd_entry;
  stt_pkg::entry_t            wr_entry;
  logic [stt_pkg::ENTRY_W-1:0] rdata;
  logic [stt_pkg::IDX_W-1:0]  rd_idx, item_idx, wr_idx;
  logic [stt_pkg::IDX_W-1:0]  sweep_cnt_q;
  logic                       out_valid_q;
  logic                       hit_q, conflict_q;
  logic signed [15:0]         found_q;
  logic                       out_free, commit, we;
  logic                       key_eq, usable, do_write;
  logic                       hit_d, conflict_d;

  // Slot index: low key bits with the side OR-ed into bit zero.
  assign rd_idx   = item_i.key[stt_pkg::IDX_W-1:0] | stt_pkg::IDX_W'(item_i.side);
  assign item_idx = item_q.key[stt_pkg::IDX_W-1:0] | stt_pkg::IDX_W'(item_q.side);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
  end

  assign rd_entry = stt_pkg::entry_t'(rdata);
  assign key_eq   = rd_entry.key == item_q.key;

  always_comb begin
    case (rd_entry.kind)
      stt_pkg::KIND_EXACT: usable = 1'b1;
      stt_pkg::KIND_LOWER: usable = rd_entry.score >= item_q.upper_window;
      stt_pkg::KIND_UPPER: usable = rd_entry.score <= item_q.lower_window;
      default:             usable = 1'b0;
    endcase
  end

  always_comb begin
    hit_d      = 1'b0;
    conflict_d = 1'b0;
    do_write   = 1'b0;
    case (item_q.op)
      stt_pkg::OP_LOOKUP: begin
        hit_d = rd_entry.valid && key_eq &&
                (rd_entry.depth >= item_q.search_depth) && usable;
      end
      stt_pkg::OP_ENTER: begin
        if (!rd_entry.valid) begin
          do_write = 1'b1;
        end else if (key_eq) begin
          do_write = (item_q.entry_kind == stt_pkg::KIND_EXACT);
        end else begin
          conflict_d = 1'b1;
          do_write   = (item_q.entry_kind == stt_pkg::KIND_EXACT) &&
                       (rd_entry.kind != stt_pkg::KIND_EXACT);
        end
      end
      default: ;
    endcase
  end

  assign wr_entry.valid = 1'b1;
  assign wr_entry.key   = item_q.key;
  assign wr_entry.depth = item_q.search_depth;
  assign wr_entry.score = item_q.entry_score;
  assign wr_entry.kind  = item_q.entry_kind;

  assign out_free = !out_valid_q || m_axis_tready;
  assign commit   = cmd_i.exec && out_free;
  assign we       = cmd_i.sweep || (commit && do_write);
  assign wr_idx   = cmd_i.sweep ? sweep_cnt_q : item_idx;

  stt_ram #(
    .WIDTH(stt_pkg::ENTRY_W),
    .DEPTH(stt_pkg::SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_idx),
    .wdata_i(cmd_i.sweep ? '0 : wr_entry),
    .re_i   (cmd_i.accept),
    .raddr_i(rd_idx),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_cnt_q <= sweep_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q      <= hit_d;
      found_q    <= hit_d ? rd_entry.score : 16'sd0;
      conflict_q <= conflict_d;
    end
  end

  assign status_o.out_free   = out_free;
  assign status_o.is_clear   = (item_q.op == stt_pkg::OP_CLEAR);
  assign status_o.sweep_last = (sweep_cnt_q == {stt_pkg::IDX_W{1'b1}});

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(stt_pkg::M_DATA_W - stt_pkg::RES_W){1'b0}},
                          conflict_q, found_q, hit_q};

  `ASSERT_NEVER(a_hit_and_conflict, clk_i, rst_ni, out_valid_q && hit_q && conflict_q)
  `ASSERT_IMPL(a_miss_zero_score, clk_i, rst_ni, (out_valid_q && !hit_q) |-> found_q == 16'sd0)
  `ASSERT_NEVER(a_write_outside_work, clk_i, rst_ni, we && !cmd_i.exec && !cmd_i.sweep)

endmodule

FILE: src/search_transposition_table_core.sv
`timescale 1ns / 1ps
// m_axis_tvalid rises after the input transfer once the slot read is registered and the output register is free.
// One item at a time: a registered slot read, then decide and write back, before the next is accepted.
// A clear item is followed by a pass that empties every slot.
// Reset (rst_ni, async, active low) starts the same pass; s_axis_tready stays low until it ends.
module search_transposition_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input item stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [1:0] op, [33:2] key, [34] side, [40:35] search_depth, [56:41] lower_window,
  // [72:57] upper_window, [88:73] entry_score, [90:89] entry_kind, rest zero
  input  logic [stt_pkg::S_DATA_W-1:0] s_axis_tdata,
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] hit, [16:1] found_score, [17] conflict, rest zero
  output logic [stt_pkg::M_DATA_W-1:0] m_axis_tdata
);

  stt_pkg::cmd_t    cmd;
  stt_pkg::status_t status;
  stt_pkg::item_t   item;

  // Unpack the transfer; padding bits above the item are ignored.
  assign item = stt_pkg::item_t'(s_axis_tdata[stt_pkg::ITEM_W-1:0]);

  // Sequencer: sweep after reset and clear, accept, then execute once the
  // output register can take the result.
  stt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Slot RAM, item register, lookup/enter decision and output register.
  stt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (cmd),
    .status_o     (status),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
